/* design/assert_macros.svh */
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("prc check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("prc check failed: next-cycle rule");

`endif

/* design/prc_pkg.sv */
// Shared types, constants and angle table for the polar/rectangular converter.
package prc_pkg;

    localparam int DATA_W      = 16;                   // coordinate / angle input width
    localparam int GUARD_W     = 16;                   // fraction bits inside the datapath
    localparam int ITERS       = 16;                   // CORDIC micro-rotations
    localparam int ANG_W       = 32;                   // angle accumulator, full turn wraps
    localparam int CW          = DATA_W + GUARD_W + 2; // datapath width, room for growth
    localparam int OUT_W       = DATA_W + 1;
    localparam int GAIN_W      = 31;
    localparam int PROD_W      = DATA_W + GAIN_W;
    localparam int PRE_SH      = 30 - GUARD_W;
    localparam int IDX_W       = 5;
    localparam int TDATA_IN_W  = ((2 * DATA_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 * OUT_W + 7) / 8) * 8;

    // 1/K, the CORDIC gain correction, in Q30
    localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(652032874);

    localparam logic [ANG_W-1:0] ANG_HALF = {1'b1, {(ANG_W-1){1'b0}}};

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [ANG_W-1:0] ATAN_LUT [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic {
        FUNC_TO_POLAR = 1'b0,
        FUNC_TO_RECT  = 1'b1
    } func_t;

    // word after the gain multiply
    typedef struct packed {
        logic                       vld;
        func_t                      func;
        logic                       origin;
        logic signed [PROD_W-1:0]   pa;
        logic signed [PROD_W-1:0]   pb;
        logic        [DATA_W-1:0]   ang;
    } prc_pre_t;

    // word travelling through the rotation stages
    typedef struct packed {
        logic                       vld;
        func_t                      func;
        logic                       origin;
        logic signed [CW-1:0]       x;
        logic signed [CW-1:0]       y;
        logic        [ANG_W-1:0]    z;
    } prc_word_t;

endpackage

/* design/polar_rectangular_convert_core.sv */
// Top level of the pipelined CORDIC polar/rectangular converter.
//
//  channel   dir  tdata (low bit up)                       tuser
//  s_axis    in   coord_a[15:0], coord_b[31:16]             func[0]
//  m_axis    out  result_a[16:0], result_b[33:17], 0 pad    -
//
// Pipeline registers, in order: gain multiply, quadrant fold, one register
// per micro-rotation, then round/saturate into the output word. One word
// enters and one leaves per cycle when both sides are ready.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up behind a stalled output and nothing is dropped or repeated.
// Reset clears only the valid bits; the data registers are not reset.
module polar_rectangular_convert_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [prc_pkg::TDATA_IN_W-1:0]         s_tdata,   // coord_a, coord_b
    input  logic [0:0]                             s_tuser,   // func
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [prc_pkg::TDATA_OUT_W-1:0]        m_tdata    // result_a, result_b
);
    import prc_pkg::*;

    prc_pre_t                 mul;
    prc_word_t                pipe [ITERS+1];
    logic [ITERS:0]           ld_pipe;
    logic                     ld_mul;
    logic                     ld_out;
    logic signed [OUT_W-1:0]  res_a;
    logic signed [OUT_W-1:0]  res_b;

    // stall chain, from the output back to the input
    assign ld_out         = !m_tvalid || m_tready;
    assign ld_pipe[ITERS] = !pipe[ITERS].vld || ld_out;

    genvar k;
    generate
        for (k = 0; k < ITERS; k++)
        begin : g_ld
            assign ld_pipe[k] = !pipe[k].vld || ld_pipe[k+1];
        end
    endgenerate

    assign ld_mul   = !mul.vld || ld_pipe[0];
    assign s_tready = ld_mul;

    prc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (s_tvalid),
        .func   (func_t'(s_tuser[0])),
        .a      (s_tdata[DATA_W-1:0]),
        .b      (s_tdata[2*DATA_W-1:DATA_W]),
        .ld_mul (ld_mul),
        .ld_rot (ld_pipe[0]),
        .mul    (mul),
        .rot    (pipe[0])
    );

    // micro-rotation i sits between pipe[i] and pipe[i+1]
    generate
        for (k = 0; k < ITERS; k++)
        begin : g_iter
            prc_stage u_stage (
                .clk   (clk),
                .rst_n (rst_n),
                .idx   (IDX_W'(k)),
                .ld    (ld_pipe[k+1]),
                .d     (pipe[k]),
                .q     (pipe[k+1])
            );
        end
    endgenerate

    prc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld      (ld_out),
        .d       (pipe[ITERS]),
        .out_vld (m_tvalid),
        .res_a   (res_a),
        .res_b   (res_b)
    );

    assign m_tdata = TDATA_OUT_W'({res_b, res_a});

endmodule

/* design/prc_front.sv */
// Front end: gain premultiply, then quadrant fold into the CORDIC start vector.
module prc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_vld,
    input  prc_pkg::func_t                     func,
    input  logic signed [prc_pkg::DATA_W-1:0]  a,
    input  logic signed [prc_pkg::DATA_W-1:0]  b,
    input  logic                               ld_mul,
    input  logic                               ld_rot,
    output prc_pkg::prc_pre_t                  mul,
    output prc_pkg::prc_word_t                 rot
);
    import prc_pkg::*;

    prc_pre_t  mul_reg, mul_next;
    prc_word_t rot_reg, rot_next;

    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic        [ANG_W-1:0] zin;

    // stage 1: scale both inputs by 1/K
    always_comb
    begin
        mul_next        = mul_reg;
        mul_next.vld    = in_vld;
        mul_next.func   = func;
        mul_next.origin = (func == FUNC_TO_POLAR) && (a == '0) && (b == '0);
        mul_next.pa     = PROD_W'(a) * PROD_W'(GAIN);
        mul_next.pb     = PROD_W'(b) * PROD_W'(GAIN);
        mul_next.ang    = b;
    end

    // stage 2: drop to GUARD_W fraction bits, fold into the right half plane
    always_comb
    begin
        xs              = CW'(mul_reg.pa >>> PRE_SH);
        ys              = CW'(mul_reg.pb >>> PRE_SH);
        zin             = {mul_reg.ang, {(ANG_W-DATA_W){1'b0}}};
        rot_next        = rot_reg;
        rot_next.vld    = mul_reg.vld;
        rot_next.func   = mul_reg.func;
        rot_next.origin = mul_reg.origin;
        if (mul_reg.func == FUNC_TO_POLAR)
        begin
            if (xs[CW-1])
            begin
                rot_next.x = -xs;
                rot_next.y = -ys;
                rot_next.z = ANG_HALF;
            end
            else
            begin
                rot_next.x = xs;
                rot_next.y = ys;
                rot_next.z = '0;
            end
        end
        else
        begin
            rot_next.y = '0;
            // back half turn: rotate by 180 degrees, negate magnitude
            if (zin[ANG_W-1] ^ zin[ANG_W-2])
            begin
                rot_next.x = -xs;
                rot_next.z = zin ^ ANG_HALF;
            end
            else
            begin
                rot_next.x = xs;
                rot_next.z = zin;
            end
        end
    end

    // only the valid bits are reset; data fields just hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg.vld <= 1'b0;
            rot_reg.vld <= 1'b0;
        end
        else
        begin
            if (ld_mul)
                mul_reg <= mul_next;
            if (ld_rot)
                rot_reg <= rot_next;
        end
    end

    assign mul = mul_reg;
    assign rot = rot_reg;

endmodule

/* design/prc_stage.sv */
// One CORDIC micro-rotation with its pipeline register.
module prc_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [prc_pkg::IDX_W-1:0]         idx,
    input  logic                              ld,
    input  prc_pkg::prc_word_t                d,
    output prc_pkg::prc_word_t                q
);
    import prc_pkg::*;

    prc_word_t            q_reg, q_next;
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    logic                 cw;

    always_comb
    begin
        xsh    = d.x >>> idx;
        ysh    = d.y >>> idx;
        // vectoring drives y to zero, rotation drives z to zero
        cw     = (d.func == FUNC_TO_POLAR) ? !d.y[CW-1] : d.z[ANG_W-1];
        q_next = d;
        if (cw)
        begin
            q_next.x = d.x + ysh;
            q_next.y = d.y - xsh;
            q_next.z = d.z + ATAN_LUT[idx];
        end
        else
        begin
            q_next.x = d.x - ysh;
            q_next.y = d.y + xsh;
            q_next.z = d.z - ATAN_LUT[idx];
        end
    end

    // only the valid bit is reset; data fields just hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg.vld <= 1'b0;
        else if (ld)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

/* design/prc_back.sv */
// Output stage: round, saturate, pick the result fields, hold the output word.
module prc_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ld,
    input  prc_pkg::prc_word_t                    d,
    output logic                                  out_vld,
    output logic signed [prc_pkg::OUT_W-1:0]      res_a,
    output logic signed [prc_pkg::OUT_W-1:0]      res_b
);
    import prc_pkg::*;

    localparam logic signed [CW-1:0]    C_HI    = CW'(2**DATA_W - 1);
    localparam logic signed [CW-1:0]    C_LO    = -C_HI - CW'(1);
    localparam logic signed [CW-1:0]    C_RND   = CW'(2**(GUARD_W-1));
    localparam logic        [ANG_W-1:0] ANG_RND = ANG_W'(2**(ANG_W-DATA_W-1));

    function automatic logic signed [OUT_W-1:0] sat_coord(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + C_RND) >>> GUARD_W;
        if (r > C_HI)
            r = C_HI;
        else if (r < C_LO)
            r = C_LO;
        return r[OUT_W-1:0];
    endfunction

    logic                        vld_reg;
    logic signed [OUT_W-1:0]     a_reg, a_next;
    logic signed [OUT_W-1:0]     b_reg, b_next;
    logic        [ANG_W-1:0]     zr;
    logic signed [DATA_W-1:0]    ang;

    always_comb
    begin
        zr  = d.z + ANG_RND;
        ang = zr[ANG_W-1 -: DATA_W];
        if (d.func == FUNC_TO_POLAR)
        begin
            a_next = d.origin ? '0 : sat_coord(d.x);
            b_next = d.origin ? '0 : OUT_W'(ang);
        end
        else
        begin
            a_next = sat_coord(d.x);
            b_next = sat_coord(d.y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ld)
            vld_reg <= d.vld;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_vld = vld_reg;
    assign res_a   = a_reg;
    assign res_b   = b_reg;

endmodule

/* design/prc_checker.sv */
// Port-level checker for the converter, bound to the top level.
`include "assert_macros.svh"

module prc_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [prc_pkg::TDATA_IN_W-1:0]         s_tdata,
    input  logic [0:0]                             s_tuser,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [prc_pkg::TDATA_OUT_W-1:0]        m_tdata
);
    import prc_pkg::*;

    logic [TDATA_OUT_W-1:0] pad;
    assign pad = m_tdata >> (2 * OUT_W);

    // stalled output word holds
    `PRC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // empty output register frees the whole pipe
    `PRC_ASSERT_NOW(a_empty_ready, clk, rst_n, !m_tvalid, s_tready)
    // a draining output never backs up the input
    `PRC_ASSERT_NOW(a_drain_ready, clk, rst_n, m_tready, s_tready)
    // fill bits above the result fields stay zero
    `PRC_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, pad == '0)

endmodule

bind polar_rectangular_convert_core prc_checker u_prc_checker (.*);
